>>> design/lpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpt_pkg
// Shared types and codes for the IPv4 prefix table.
// ----------------------------------------------------------------------------
package lpt_pkg;

  localparam int unsigned DEF_ENTRIES = 1024;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_REMOVE  = 2'd1,
    ACT_EXACT   = 2'd2,
    ACT_LONGEST = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_PRESENT   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_USED  = 2'd1,
    SLOT_DEAD  = 2'd2
  } slot_state_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_READ,
    S_CHECK,
    S_DONE
  } fsm_t;

  typedef struct packed {
    slot_state_t  st;
    logic [31:0]  prefix;
    logic [5:0]   len;
    logic [31:0]  value;
  } entry_t;

endpackage
`default_nettype wire

>>> design/lpt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpt_ram
// Slot memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lpt_ram #(
  parameter int unsigned DEPTH = lpt_pkg::DEF_ENTRIES,
  parameter int unsigned IW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [IW-1:0]    wr_addr,
  input  wire lpt_pkg::entry_t  wr_data,
  input  wire logic [IW-1:0]    rd_addr,
  output lpt_pkg::entry_t       rd_data
);
  import lpt_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> design/ipv4_prefix_table_lpm_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_prefix_table_lpm_core
// Hashed prefix table (open addressing, linear probe, tombstones on remove)
// with exact and longest-prefix lookup.
// ----------------------------------------------------------------------------
// Each probe is a memory read (S_READ), then a compare (S_CHECK), set by the
// single read port of the slot memory. Exact ops make P probes (1 on a lightly
// loaded table, up to ENTRIES) and then return the result. Longest-
// prefix lookup repeats the search per length: up to 33 searches.
// After reset the block sweeps every slot of the memory to empty and
// holds s_tready low meanwhile. One word in flight at a time.
module ipv4_prefix_table_lpm_core #(
  parameter int unsigned ENTRIES = lpt_pkg::DEF_ENTRIES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // action[1:0], address[33:2], prefix_length[39:34], entry_value[71:40]
  input  wire logic [71:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // hit[0], found_value[32:1], matched_length[38:33], status[40:39], zero pad
  output logic [47:0]      m_tdata
);
  import lpt_pkg::*;

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  fsm_t state, state_next;

  action_t      act;
  logic [31:0]  addr;
  logic [5:0]   cur_len;
  logic [31:0]  val;
  logic [IW-1:0] idx;
  logic [IW-1:0] cnt;
  logic [IW-1:0] free_idx;
  logic          have_free;

  logic          res_hit;
  logic [31:0]   res_value;
  logic [5:0]    res_len;
  status_t       res_status;

  entry_t        rd_data, wr_data;
  logic          we;
  logic [IW-1:0] wr_addr;

  logic [31:0]   key, mix;
  logic [IW-1:0] hfold, hstart, idx_inc;
  logic          match, is_empty, freeish, last;
  logic [5:0]    in_len;

  lpt_ram #(.DEPTH(ENTRIES), .IW(IW)) u_ram (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  assign s_tready = (state == S_IDLE);
  assign in_len   = (s_tdata[39:34] > 6'd32) ? 6'd32 : s_tdata[39:34];

  always_comb begin
    key   = addr & ~(32'hFFFF_FFFF >> cur_len);
    mix   = key ^ {cur_len, 26'd0} ^ {26'd0, cur_len};
    hfold = '0;
    for (int b = 0; b < 32; b++) begin
      hfold[b % IW] = hfold[b % IW] ^ mix[b];
    end
    // fold may land past the last slot when ENTRIES is not a power of two
    hstart   = ({1'b0, hfold} >= (IW+1)'(ENTRIES)) ? hfold - LAST_IDX - 1'b1 : hfold;
    idx_inc  = (idx == LAST_IDX) ? '0 : idx + 1'b1;
    match    = (rd_data.st == SLOT_USED) && (rd_data.len == cur_len) &&
               (rd_data.prefix == key);
    is_empty = (rd_data.st == SLOT_EMPTY);
    freeish  = (rd_data.st != SLOT_USED);
    last     = (cnt == LAST_IDX);
  end

  // next state and memory writes
  always_comb begin
    state_next = state;
    we         = 1'b0;
    wr_addr    = idx;
    wr_data    = '{st: SLOT_EMPTY, prefix: key, len: cur_len, value: val};
    case (state)
      S_CLEAR: begin
        we = 1'b1;
        if (idx == LAST_IDX) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) state_next = S_START;
      end
      S_START: state_next = S_READ;
      S_READ:  state_next = S_CHECK;
      S_CHECK: begin
        if (match) begin
          state_next = S_DONE;
          if (act == ACT_REMOVE) begin
            we         = 1'b1;
            wr_data.st = SLOT_DEAD;
          end
        end else if (is_empty || last) begin
          state_next = S_DONE;
          if (act == ACT_INSERT && (have_free || freeish)) begin
            we         = 1'b1;
            wr_addr    = have_free ? free_idx : idx;
            wr_data.st = SLOT_USED;
          end else if (act == ACT_LONGEST && cur_len != 6'd0) begin
            state_next = S_START;
          end
        end else begin
          state_next = S_READ;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: idx <= idx_inc;
        S_IDLE: begin
          if (s_tvalid) begin
            act        <= action_t'(s_tdata[1:0]);
            addr       <= s_tdata[33:2];
            cur_len    <= in_len;
            val        <= s_tdata[71:40];
            res_hit    <= 1'b0;
            res_value  <= '0;
            res_len    <= '0;
            res_status <= ST_DONE;
          end
        end
        S_START: begin
          idx       <= hstart;
          cnt       <= '0;
          have_free <= 1'b0;
        end
        S_CHECK: begin
          if (!have_free && freeish) begin
            have_free <= 1'b1;
            free_idx  <= idx;
          end
          if (match) begin
            case (act)
              ACT_INSERT: res_status <= ST_PRESENT;
              ACT_REMOVE: res_status <= ST_DONE;
              default: begin
                res_hit   <= 1'b1;
                res_value <= rd_data.value;
                res_len   <= cur_len;
              end
            endcase
          end else if (is_empty || last) begin
            case (act)
              ACT_INSERT: begin
                if (!(have_free || freeish)) res_status <= ST_FULL;
              end
              ACT_EXACT: res_status <= ST_NOT_FOUND;
              ACT_LONGEST: begin
                if (cur_len == 6'd0) res_status <= ST_NOT_FOUND;
                else                 cur_len    <= cur_len - 6'd1;
              end
              default: res_status <= ST_DONE;
            endcase
          end else begin
            idx <= idx_inc;
            cnt <= cnt + 1'b1;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'd0, res_status, res_len, res_value, res_hit};
          end
        end
        default: ;
      endcase
      if (m_tvalid && m_tready && !(state == S_DONE)) m_tvalid <= 1'b0;
    end
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !s_tready)
    else $error("input accepted during clear sweep");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ || state == S_CHECK) |-> (cur_len <= 6'd32))
    else $error("prefix length out of range");

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> ({1'b0, cnt} < (IW+1)'(ENTRIES)))
    else $error("probe count past table size");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_CLEAR || state == S_CHECK))
    else $error("memory write outside clear or check");

endmodule
`default_nettype wire
